// File: rtl/hidq_pkg.sv
// Shared types, codes and helper function of the HID tick report queue.
`default_nettype none

package hidq_pkg;

  // Item codes carried in the low bits of the input beat.
  localparam logic [2:0] OP_UP_PRESS   = 3'd0;
  localparam logic [2:0] OP_DOWN_PRESS = 3'd1;
  localparam logic [2:0] OP_UP_CONT    = 3'd2;
  localparam logic [2:0] OP_DOWN_CONT  = 3'd3;
  localparam logic [2:0] OP_DRAIN      = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_CW_TRANSPORT   = 3'd0;
  localparam logic [2:0] REG_DOWN_TRANSPORT = 3'd1;
  localparam logic [2:0] REG_UP_TEMPLATE    = 3'd2;
  localparam logic [2:0] REG_DOWN_TEMPLATE  = 3'd3;
  localparam logic [2:0] REG_SUBSCRIBE_MASK = 3'd4;

  // Attribute indexes of the four notifiable reports.
  localparam logic [7:0] FIRST_TRANSPORT = 8'd5;
  localparam logic [7:0] LAST_TRANSPORT  = 8'd17;

  // Configuration register set.
  typedef struct packed {
    logic [7:0]  cw_transport;
    logic [7:0]  down_transport;
    logic [63:0] up_template;
    logic [63:0] down_template;
    logic [3:0]  subscribe_mask;
  } cfg_t;

  // A formatted tick, ready to be pushed.
  typedef struct packed {
    logic        keep;
    logic [7:0]  transport;
    logic [63:0] report;
    logic        release_flag;
  } tick_t;

  // True when the transport is one of the four reports and its bit is set.
  function automatic logic notifiable(input logic [7:0] t, input logic [3:0] mask);
    logic [7:0] off;
    off = t - FIRST_TRANSPORT;
    return (t >= FIRST_TRANSPORT) && (t <= LAST_TRANSPORT) && (off[1:0] == 2'd0)
           && mask[off[3:2]];
  endfunction

endpackage

`default_nettype wire

// File: rtl/hidq_tick_fmt.sv
// Tick formatter: picks the direction's transport and template and places the delta.
`default_nettype none

module hidq_tick_fmt import hidq_pkg::*; #(
  parameter int REPORT_BYTES = 8
) (
  input  logic              [2:0] opcode,
  input  logic signed       [7:0] delta,
  input  cfg_t                    cfg,
  output tick_t                   tick
);

  localparam logic [63:0] RMASK = (REPORT_BYTES >= 8) ? {64{1'b1}}
                                : ((64'd1 << (8 * REPORT_BYTES)) - 64'd1);

  logic        is_up;
  logic        is_press;
  logic        is_tick;
  logic [7:0]  transport;
  logic [63:0] base;
  logic [63:0] rep;
  logic        found;

  // Direction and kind of the tick.
  assign is_up    = (opcode == OP_UP_PRESS) || (opcode == OP_UP_CONT);
  assign is_press = (opcode == OP_UP_PRESS) || (opcode == OP_DOWN_PRESS);
  assign is_tick  = (opcode <= OP_DOWN_CONT);

  assign transport = is_up ? cfg.cw_transport : cfg.down_transport;
  assign base      = (is_up ? cfg.up_template : cfg.down_template) & RMASK;

  // A continuous tick overwrites the first nonzero byte with the delta.
  always_comb begin
    found = 1'b0;
    rep   = base;
    for (int i = 0; i < REPORT_BYTES; i++) begin
      if (!found && (base[8*i +: 8] != 8'd0)) begin
        rep[8*i +: 8] = delta;
        found         = 1'b1;
      end
    end
    if (is_press) begin
      rep = base;
    end
  end

  assign tick.keep         = is_tick && notifiable(transport, cfg.subscribe_mask);
  assign tick.transport    = transport;
  assign tick.report       = rep;
  assign tick.release_flag = is_press;

endmodule

`default_nettype wire

// File: rtl/hid_tick_report_queue.sv
// Top level of the HID tick report queue: configuration, entry memory and drain control.
`default_nettype none

// A tick beat is formatted, filtered by the subscription mask and written into the entry
// memory; a push into a full queue overwrites the oldest entry and bumps the drop counter.
// A drain beat reads the oldest entry through the registered read port of the entry
// memory, then presents one or two output beats through the output register, the second
// being the all-zero release report; s_tready stays low from the drain beat until its last
// output beat is taken. A drain of an empty queue, or of an entry whose report is no longer
// subscribed, ends in idle with no output. Entries need no initialization after reset.
module hid_tick_report_queue import hidq_pkg::*; #(
  parameter int QUEUE_DEPTH  = 32,
  parameter int REPORT_BYTES = 8
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // opcode[2:0], delta[10:3], zero fill
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // out_transport[7:0], out_report[71:8],
                                  // dropped_count[103:72]
  output logic         m_tlast,
  output logic         m_tuser    // is_release
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RW     = 8 * REPORT_BYTES;
  localparam int EW     = 1 + 8 + RW;
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DATA, ST_REL} state_t;

  state_t            state;
  cfg_t              cfg;
  tick_t             tick;
  logic [PTR_W-1:0]  read_pointer;
  logic [PTR_W-1:0]  write_pointer;
  logic [FILL_W-1:0] fill_count;
  logic [31:0]       overflow_drops;
  logic [EW-1:0]     mem [QUEUE_DEPTH];
  logic [EW-1:0]     rd_data;
  logic              accept;
  logic              is_drain;
  logic              mem_we;
  logic              mem_re;
  logic              rd_release;
  logic [7:0]        rd_transport;
  logic [RW-1:0]     rd_report;
  logic              rel_pend;
  logic [7:0]        out_transport;
  logic [63:0]       out_report;
  logic [31:0]       out_dropped;

  function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cw_transport   <= FIRST_TRANSPORT;
      cfg.down_transport <= FIRST_TRANSPORT;
      cfg.up_template    <= '0;
      cfg.down_template  <= '0;
      cfg.subscribe_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CW_TRANSPORT:   cfg.cw_transport   <= cfg_data[7:0];
        REG_DOWN_TRANSPORT: cfg.down_transport <= cfg_data[7:0];
        REG_UP_TEMPLATE:    cfg.up_template    <= cfg_data;
        REG_DOWN_TEMPLATE:  cfg.down_template  <= cfg_data;
        REG_SUBSCRIBE_MASK: cfg.subscribe_mask <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Tick formatting.
  hidq_tick_fmt #(
    .REPORT_BYTES(REPORT_BYTES)
  ) u_fmt (
    .opcode(s_tdata[2:0]),
    .delta (s_tdata[10:3]),
    .cfg   (cfg),
    .tick  (tick)
  );

  // Handshake decode.
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_drain = (s_tdata[2:0] == OP_DRAIN);
  assign mem_we   = accept && !is_drain && tick.keep;
  assign mem_re   = accept && is_drain && (fill_count != '0);

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_pointer] <= {tick.release_flag, tick.transport, tick.report[RW-1:0]};
    end
    if (mem_re) begin
      rd_data <= mem[read_pointer];
    end
  end

  assign {rd_release, rd_transport, rd_report} = rd_data;

  // Queue pointers, drop counter and drain sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      m_tvalid       <= 1'b0;
      read_pointer   <= '0;
      write_pointer  <= '0;
      fill_count     <= '0;
      overflow_drops <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (mem_re) begin
            read_pointer <= next_index(read_pointer);
            fill_count   <= fill_count - 1'b1;
            state        <= ST_READ;
          end else if (mem_we) begin
            write_pointer <= next_index(write_pointer);
            if (fill_count == FILL_MAX) begin
              read_pointer   <= next_index(read_pointer);
              overflow_drops <= overflow_drops + 32'd1;
            end else begin
              fill_count <= fill_count + 1'b1;
            end
          end
        end
        ST_READ: begin
          if (notifiable(rd_transport, cfg.subscribe_mask)) begin
            out_transport <= rd_transport;
            out_report    <= 64'(rd_report);
            out_dropped   <= overflow_drops;
            m_tuser       <= 1'b0;
            m_tlast       <= !rd_release;
            rel_pend      <= rd_release;
            m_tvalid      <= 1'b1;
            state         <= ST_DATA;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DATA: begin
          if (m_tready) begin
            if (rel_pend) begin
              out_report <= '0;
              m_tuser    <= 1'b1;
              m_tlast    <= 1'b1;
              state      <= ST_REL;
            end else begin
              m_tvalid <= 1'b0;
              state    <= ST_IDLE;
            end
          end
        end
        ST_REL: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {out_dropped, out_report, out_transport};

  // The block never takes input while a result beat is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while an output beat is pending");

  // The fill count never exceeds the queue depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_MAX)
    else $error("fill count beyond queue depth");

  // A release report always closes its drain.
  a_release_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("release beat not marked last");

  // A taken beat that is not last is followed by the release beat.
  a_release_follows: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser))
    else $error("missing release beat after a press report");

endmodule

`default_nettype wire
